@@ hw/rtl/av_bv_id_codec_unit_macros.svh @@
// Assertion macros for the ID codec checker.
`ifndef AV_BV_ID_CODEC_UNIT_MACROS_SVH
`define AV_BV_ID_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define AVBV_ASSERT_COMB(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define AVBV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define AVBV_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/avbv_pkg.sv @@
// Types, constants and table functions of the ID codec.
package avbv_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int RADIX      = 58;
    localparam int DIGIT_W    = 6;
    localparam int SYM_W      = 8;
    localparam int VAL_W      = 36;
    localparam int HALF_W     = VAL_W / 2;
    localparam int MASK_W     = 32;
    localparam int OFFSET_W   = 35;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OFFSET_W;

    localparam logic [MASK_W-1:0]   XOR_MASK_RST   = 32'd177451812;
    localparam logic [OFFSET_W-1:0] ADD_OFFSET_RST = 35'd8728348608;

    localparam logic [CFG_IDX_W-1:0] CFG_XOR_MASK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_OFFSET = 1'b1;

    // Reciprocal division by 58: q = (x * DIV_MUL) >> DIV_SHIFT is exact for x < 2^24.
    localparam int DIV_X_W   = 24;
    localparam int DIV_M_W   = 25;
    localparam int DIV_P_W   = DIV_X_W + DIV_M_W;
    localparam int DIV_SHIFT = 30;
    localparam int DIV_Q_W   = DIV_P_W - DIV_SHIFT;
    localparam logic [DIV_M_W-1:0] DIV_MUL = 25'd18512791;
    localparam logic [DIGIT_W-1:0] RADIX_D = 6'd58;
    localparam logic [VAL_W-1:0]   RADIX_V = 36'd58;

    localparam logic [SYM_W*RADIX-1:0] ALPHABET =
        "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SYM   = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef logic [DIGIT_W-1:0] t_digit;

    // Work item between digit steps: remaining quotient (encode) or running sum (decode).
    typedef struct packed {
        t_cmd                         cmd;
        logic                         bad;
        logic [VAL_W-1:0]             val;
        t_digit [NUM_DIGITS-1:0]      dig;
    } t_work;

    // Work item between the two halves of one digit step.
    typedef struct packed {
        t_cmd                         cmd;
        logic                         bad;
        logic [HALF_W-1:0]            hi;
        t_digit                       rem;
        logic [HALF_W-1:0]            lo;
        t_digit [NUM_DIGITS-1:0]      dig;
    } t_mid;

    typedef struct packed {
        logic [DIV_Q_W-1:0] q;
        t_digit             r;
    } t_divres;

    typedef struct packed {
        logic   hit;
        t_digit idx;
    } t_symidx;

    function automatic t_divres div58(input logic [DIV_X_W-1:0] x);
        logic [DIV_P_W-1:0] prod;
        t_divres            res;
        prod  = {{DIV_M_W{1'b0}}, x} * {{DIV_X_W{1'b0}}, DIV_MUL};
        res.q = prod[DIV_P_W-1:DIV_SHIFT];
        // The remainder is below 64, so six low bits of x - 58q are enough.
        res.r = x[DIGIT_W-1:0] - (res.q[DIGIT_W-1:0] * RADIX_D);
        return res;
    endfunction

    function automatic logic [SYM_W-1:0] sym_char(input t_digit d);
        logic [SYM_W-1:0] c;
        c = '0;
        for (int k = 0; k < RADIX; k++) begin
            if (d == DIGIT_W'(k)) begin
                c = ALPHABET[SYM_W*(RADIX-1-k) +: SYM_W];
            end
        end
        return c;
    endfunction

    function automatic t_symidx sym_lookup(input logic [SYM_W-1:0] c);
        t_symidx res;
        res = '0;
        for (int k = 0; k < RADIX; k++) begin
            if (ALPHABET[SYM_W*(RADIX-1-k) +: SYM_W] == c) begin
                res.hit = 1'b1;
                res.idx = DIGIT_W'(k);
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/avbv_digit_step.sv @@
// One base-58 digit step of the codec pipeline, split over two register stages.
module avbv_digit_step
    import avbv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_stall,
    output t_work o_work
);

    logic    r_va;
    logic    r_vb;
    t_mid    r_mid;
    t_mid    n_mid;
    t_work   r_work;
    t_work   n_work;
    t_divres div_a;
    t_divres div_b;
    logic    en_a;
    logic    en_b;
    t_digit  new_dig;

    // A stage moves on when it is empty or the stage after it moves on.
    assign en_b    = !r_vb || !i_stall;
    assign en_a    = !r_va || en_b;
    assign o_stall = !en_a;
    assign o_valid = r_vb;
    assign o_work  = r_work;

    // First half: for encode, divide the upper half of the value by 58; decode passes it through.
    always_comb begin
        div_a     = div58({{(DIV_X_W-HALF_W){1'b0}}, i_work.val[VAL_W-1:HALF_W]});
        n_mid.cmd = i_work.cmd;
        n_mid.bad = i_work.bad;
        n_mid.lo  = i_work.val[HALF_W-1:0];
        n_mid.dig = i_work.dig;
        if (i_work.cmd == CMD_ENCODE) begin
            n_mid.hi  = div_a.q[HALF_W-1:0];
            n_mid.rem = div_a.r;
        end else begin
            n_mid.hi  = i_work.val[VAL_W-1:HALF_W];
            n_mid.rem = '0;
        end
    end

    // Second half: finish the division, or fold one decode digit in by Horner's rule.
    always_comb begin
        div_b      = div58({r_mid.rem, r_mid.lo});
        n_work.cmd = r_mid.cmd;
        n_work.bad = r_mid.bad;
        if (r_mid.cmd == CMD_ENCODE) begin
            n_work.val = {r_mid.hi, div_b.q[HALF_W-1:0]};
            new_dig    = div_b.r;
        end else begin
            n_work.val = ({r_mid.hi, r_mid.lo} * RADIX_V)
                         + {{(VAL_W-DIGIT_W){1'b0}}, r_mid.dig[NUM_DIGITS-1]};
            new_dig    = '0;
        end
        n_work.dig = {r_mid.dig[NUM_DIGITS-2:0], new_dig};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_mid <= n_mid;
        end
        if (en_b && r_va) begin
            r_work <= n_work;
        end
    end

endmodule

@@ hw/rtl/av_bv_id_codec_unit.sv @@
// Top level of the numeric ID to base-58 code converter.
//
// Usage: each input transfer carries a command and both payloads. Encode
// (i_cmd = 0) takes i_av_number, XORs it with the xor_mask register, adds
// add_offset and returns the six base-58 symbols of the sum on o_code_0..5
// (code positions 11,10,3,8,4,6; the rest of the code is fixed text).
// Decode (i_cmd = 1) maps i_sym_0..5 back to digits, forms the weighted sum,
// subtracts add_offset and XORs the mask; o_status flags an unknown symbol
// or a sum below the offset. Every input transfer gives one output transfer,
// in order.
// Timing: one transfer per cycle is sustained while i_stall is low. The
// pipeline has one stage for the mask/offset add and symbol lookup, six
// digit steps of two stages each (one reciprocal multiply by 1/58 per
// stage), and the output register.
// Reset (synchronous, active low) empties the pipeline and restores both
// registers to their defaults. When the receiver holds i_stall, the output
// holds its transfer, and earlier stages keep filling any empty slots before
// o_stall is raised toward the sender.
// The configuration port must only be written while no transfer is in flight.
module av_bv_id_codec_unit
    import avbv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_cmd,
    input  logic [MASK_W-1:0]     i_av_number,
    input  logic [SYM_W-1:0]      i_sym_0,
    input  logic [SYM_W-1:0]      i_sym_1,
    input  logic [SYM_W-1:0]      i_sym_2,
    input  logic [SYM_W-1:0]      i_sym_3,
    input  logic [SYM_W-1:0]      i_sym_4,
    input  logic [SYM_W-1:0]      i_sym_5,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VAL_W-1:0]      o_av_result,
    output logic [SYM_W-1:0]      o_code_0,
    output logic [SYM_W-1:0]      o_code_1,
    output logic [SYM_W-1:0]      o_code_2,
    output logic [SYM_W-1:0]      o_code_3,
    output logic [SYM_W-1:0]      o_code_4,
    output logic [SYM_W-1:0]      o_code_5,
    output logic [1:0]            o_status
);

    // Configuration registers.
    logic [MASK_W-1:0]   r_xor_mask;
    logic [OFFSET_W-1:0] r_add_offset;

    // Entry stage.
    logic                                r_v0;
    t_work                               r_s0;
    t_work                               n_s0;
    logic                                en0;
    logic [NUM_DIGITS-1:0][SYM_W-1:0]    in_sym;
    t_symidx [NUM_DIGITS-1:0]            sym_idx;

    // Digit step chain; index k is the input side of step k.
    t_work w_chain [NUM_DIGITS+1];
    logic  v_chain [NUM_DIGITS+1];
    logic  s_chain [NUM_DIGITS+1];

    // Output stage.
    logic                             r_ov;
    logic [VAL_W-1:0]                 r_av_result;
    logic [VAL_W-1:0]                 n_av_result;
    logic [NUM_DIGITS-1:0][SYM_W-1:0] r_code;
    logic [NUM_DIGITS-1:0][SYM_W-1:0] n_code;
    t_status                          r_status;
    t_status                          n_status;
    logic                             en_out;
    t_work                            last_w;

    // Register writes are masked to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor_mask   <= XOR_MASK_RST;
            r_add_offset <= ADD_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_XOR_MASK:   r_xor_mask   <= i_cfg_data[MASK_W-1:0];
                CFG_ADD_OFFSET: r_add_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_sym = {i_sym_5, i_sym_4, i_sym_3, i_sym_2, i_sym_1, i_sym_0};

    // Entry stage: the encode sum and the decode symbol lookup run side by side.
    always_comb begin
        n_s0.cmd = t_cmd'(i_cmd);
        n_s0.bad = 1'b0;
        n_s0.dig = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            sym_idx[i] = sym_lookup(in_sym[i]);
        end
        if (n_s0.cmd == CMD_ENCODE) begin
            n_s0.val = {{(VAL_W-MASK_W){1'b0}}, i_av_number ^ r_xor_mask}
                       + {{(VAL_W-OFFSET_W){1'b0}}, r_add_offset};
        end else begin
            n_s0.val = '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                n_s0.dig[i] = sym_idx[i].idx;
                if (!sym_idx[i].hit) begin
                    n_s0.bad = 1'b1;
                end
            end
        end
    end

    assign en0     = !r_v0 || !s_chain[0];
    assign o_stall = !en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en0) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r_s0 <= n_s0;
        end
    end

    assign w_chain[0] = r_s0;
    assign v_chain[0] = r_v0;

    // Six digit steps. Encode shifts out the least significant digit first;
    // decode consumes the most significant index first.
    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_step
        avbv_digit_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_chain[k]),
            .o_stall (s_chain[k]),
            .i_work  (w_chain[k]),
            .o_valid (v_chain[k+1]),
            .i_stall (s_chain[k+1]),
            .o_work  (w_chain[k+1])
        );
    end

    assign last_w               = w_chain[NUM_DIGITS];
    assign en_out               = !r_ov || !i_stall;
    assign s_chain[NUM_DIGITS]  = !en_out;

    // Output stage: alphabet mapping for encode, offset and mask for decode.
    always_comb begin
        n_av_result = '0;
        n_code      = '0;
        n_status    = ST_OK;
        if (last_w.cmd == CMD_ENCODE) begin
            // After six shifts the least significant digit sits at the top.
            for (int i = 0; i < NUM_DIGITS; i++) begin
                n_code[i] = sym_char(last_w.dig[NUM_DIGITS-1-i]);
            end
        end else if (last_w.bad) begin
            n_status = ST_BAD_SYM;
        end else begin
            n_av_result = (last_w.val - {{(VAL_W-OFFSET_W){1'b0}}, r_add_offset})
                          ^ {{(VAL_W-MASK_W){1'b0}}, r_xor_mask};
            if (last_w.val < {{(VAL_W-OFFSET_W){1'b0}}, r_add_offset}) begin
                n_status = ST_UNDERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= v_chain[NUM_DIGITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && v_chain[NUM_DIGITS]) begin
            r_av_result <= n_av_result;
            r_code      <= n_code;
            r_status    <= n_status;
        end
    end

    assign o_valid     = r_ov;
    assign o_av_result = r_av_result;
    assign o_code_0    = r_code[0];
    assign o_code_1    = r_code[1];
    assign o_code_2    = r_code[2];
    assign o_code_3    = r_code[3];
    assign o_code_4    = r_code[4];
    assign o_code_5    = r_code[5];
    assign o_status    = r_status;

endmodule

@@ hw/rtl/avbv_checker.sv @@
// Port-level checker for the ID codec and its bind to the top level.
`include "av_bv_id_codec_unit_macros.svh"

module avbv_checker
    import avbv_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_cmd,
    input logic [MASK_W-1:0]     i_av_number,
    input logic [SYM_W-1:0]      i_sym_0,
    input logic [SYM_W-1:0]      i_sym_1,
    input logic [SYM_W-1:0]      i_sym_2,
    input logic [SYM_W-1:0]      i_sym_3,
    input logic [SYM_W-1:0]      i_sym_4,
    input logic [SYM_W-1:0]      i_sym_5,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [VAL_W-1:0]      o_av_result,
    input logic [SYM_W-1:0]      o_code_0,
    input logic [SYM_W-1:0]      o_code_1,
    input logic [SYM_W-1:0]      o_code_2,
    input logic [SYM_W-1:0]      o_code_3,
    input logic [SYM_W-1:0]      o_code_4,
    input logic [SYM_W-1:0]      o_code_5,
    input logic [1:0]            o_status
);

    // Reset empties the whole pipeline, so nothing is shown or held back.
    `AVBV_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid && !o_stall, "pipeline not empty after reset")

    // A stalled result stays on the port unchanged.
    `AVBV_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_av_result) && $stable(o_status) && $stable(o_code_0) && $stable(o_code_5), "stalled result changed")

    // An unknown symbol yields an all-zero result.
    `AVBV_ASSERT_COMB(a_bad_sym_zero, o_valid && o_status == ST_BAD_SYM, o_av_result == '0 && o_code_0 == '0 && o_code_5 == '0, "bad symbol result not cleared")

    // Encode results always carry alphabet symbols, a zero number and status ok.
    `AVBV_ASSERT_COMB(a_encode_clean, o_valid && o_code_0 != '0, o_code_5 != '0 && o_status == ST_OK && o_av_result == '0, "encode result inconsistent")

endmodule

bind av_bv_id_codec_unit avbv_checker u_avbv_checker (.*);

@@ tb/testbench.sv @@
// Self-checking regression of the base-58 video ID converter.
`timescale 1ns / 1ps

module testbench
    import avbv_pkg::*;
();

    // Idle margin kept after the last expected result has come out.
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int BURST_ITEMS    = 80;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 215;

    // The 58 code symbols, digit 0 first.
    localparam logic [8*58-1:0] CODE_ALPHABET =
        "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";
    localparam longint unsigned SPAN_58_6 = 64'd38068692544;

    typedef logic [NUM_DIGITS-1:0][SYM_W-1:0] t_syms;

    typedef struct packed {
        logic [VAL_W-1:0] av;
        t_syms            code;
        t_status          status;
    } t_conv_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_cmd;
    logic [MASK_W-1:0]     i_av_number;
    logic [SYM_W-1:0]      i_sym_0;
    logic [SYM_W-1:0]      i_sym_1;
    logic [SYM_W-1:0]      i_sym_2;
    logic [SYM_W-1:0]      i_sym_3;
    logic [SYM_W-1:0]      i_sym_4;
    logic [SYM_W-1:0]      i_sym_5;
    logic                  o_valid;
    logic                  i_stall;
    logic [VAL_W-1:0]      o_av_result;
    logic [SYM_W-1:0]      o_code_0;
    logic [SYM_W-1:0]      o_code_1;
    logic [SYM_W-1:0]      o_code_2;
    logic [SYM_W-1:0]      o_code_3;
    logic [SYM_W-1:0]      o_code_4;
    logic [SYM_W-1:0]      o_code_5;
    logic [1:0]            o_status;

    av_bv_id_codec_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_av_number (i_av_number),
        .i_sym_0     (i_sym_0),
        .i_sym_1     (i_sym_1),
        .i_sym_2     (i_sym_2),
        .i_sym_3     (i_sym_3),
        .i_sym_4     (i_sym_4),
        .i_sym_5     (i_sym_5),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_av_result (o_av_result),
        .o_code_0    (o_code_0),
        .o_code_1    (o_code_1),
        .o_code_2    (o_code_2),
        .o_code_3    (o_code_3),
        .o_code_4    (o_code_4),
        .o_code_5    (o_code_5),
        .o_status    (o_status)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copies of the two configuration registers.
    logic [MASK_W-1:0]   mask_shadow;
    logic [OFFSET_W-1:0] offset_shadow;

    // Expected conversions, oldest first, one per accepted input transfer.
    t_conv_result pending_results[$];

    // Idling controls for the sender and the receiver.
    bit send_idling;
    bit recv_idling;
    bit holdoff_request;

    int fail_count;
    int encode_count;
    int decode_count;
    int bad_symbol_count;
    int underflow_count;
    int cfg_write_count;
    int input_stall_cycles;
    int holdoff_total;

    function automatic logic [SYM_W-1:0] alpha_char(input int k);
        return CODE_ALPHABET[8*(57-k) +: 8];
    endfunction

    // Alphabet position of a symbol, or -1 when the symbol is not a code character.
    function automatic int symbol_rank(input logic [SYM_W-1:0] c);
        int rank;
        rank = -1;
        for (int k = 0; k < 58; k++) begin
            if (alpha_char(k) == c) begin
                rank = k;
            end
        end
        return rank;
    endfunction

    // Six base-58 symbols of a value, least significant digit first; higher parts drop out.
    function automatic t_syms symbols_of(input longint unsigned value);
        t_syms syms;
        longint unsigned t;
        t = value;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            syms[i] = alpha_char(int'(t % 58));
            t = t / 58;
        end
        return syms;
    endfunction

    function automatic t_conv_result predict_conversion(input t_cmd cmd,
                                                        input logic [MASK_W-1:0] av,
                                                        input t_syms syms);
        t_conv_result res;
        longint unsigned t;
        longint unsigned sum;
        longint unsigned weight;
        longint unsigned offset;
        bit bad;
        int rank;
        res = '0;
        offset = longint'(offset_shadow);
        if (cmd == CMD_ENCODE) begin
            t = longint'(av ^ mask_shadow) + offset;
            res.code = symbols_of(t);
            res.status = ST_OK;
        end else begin
            sum = 0;
            weight = 1;
            bad = 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                rank = symbol_rank(syms[i]);
                if (rank < 0) begin
                    bad = 1'b1;
                end else begin
                    sum += longint'(rank) * weight;
                end
                weight *= 58;
            end
            if (bad) begin
                res.status = ST_BAD_SYM;
            end else begin
                t = (sum - offset) ^ longint'(mask_shadow);
                res.av = t[VAL_W-1:0];
                res.status = (sum < offset) ? ST_UNDERFLOW : ST_OK;
            end
        end
        return res;
    endfunction

    // Offers one transfer and returns once it has been taken; valid is left high so that a
    // following transfer can go out back to back.
    task automatic send_transfer(input t_cmd cmd, input logic [MASK_W-1:0] av,
                                 input t_syms syms);
        int gap;
        t_conv_result exp;
        gap = 0;
        if (send_idling && $urandom_range(0, 9) >= 6) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_av_number <= av;
        i_sym_0     <= syms[0];
        i_sym_1     <= syms[1];
        i_sym_2     <= syms[2];
        i_sym_3     <= syms[3];
        i_sym_4     <= syms[4];
        i_sym_5     <= syms[5];
        do @(posedge i_clk); while (o_stall);
        exp = predict_conversion(cmd, av, syms);
        pending_results.push_back(exp);
        if (cmd == CMD_ENCODE) begin
            encode_count++;
        end else begin
            decode_count++;
            if (exp.status == ST_BAD_SYM) bad_symbol_count++;
            if (exp.status == ST_UNDERFLOW) underflow_count++;
        end
    endtask

    task automatic send_encode(input logic [MASK_W-1:0] av);
        send_transfer(CMD_ENCODE, av, {$urandom, 16'($urandom_range(0, 65535))});
    endtask

    task automatic send_decode(input t_syms syms);
        send_transfer(CMD_DECODE, $urandom, syms);
    endtask

    // Stops offering and waits until every expected transfer has come out.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes one register; the caller makes sure the pipeline is empty.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_XOR_MASK) begin
            mask_shadow = data[MASK_W-1:0];
        end else begin
            offset_shadow = data[OFFSET_W-1:0];
        end
        cfg_write_count++;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mask_data,
                              input logic [CFG_DATA_W-1:0] offset_data);
        drain_pipeline();
        write_register(CFG_XOR_MASK, mask_data);
        write_register(CFG_ADD_OFFSET, offset_data);
    endtask

    // Decodes of the sums just at and just below the offset.
    task automatic send_offset_edges();
        send_decode(symbols_of(longint'(offset_shadow)));
        if (offset_shadow != '0) begin
            send_decode(symbols_of(longint'(offset_shadow) - 1));
        end
    endtask

    // Reset values: extremes of the number, symbol extremes and unknown symbols.
    task automatic test_directed_defaults();
        t_syms syms;
        send_encode(32'h0000_0000);
        send_encode(32'hFFFF_FFFF);
        send_encode(32'h5555_5555);
        send_encode(32'hAAAA_AAAA);
        // All-zero digits give a sum far below the default offset.
        send_decode({NUM_DIGITS{alpha_char(0)}});
        send_decode({NUM_DIGITS{alpha_char(57)}});
        // A clean round trip of a small ID.
        send_decode(symbols_of(longint'(32'd170001 ^ mask_shadow) + longint'(offset_shadow)));
        syms = {NUM_DIGITS{alpha_char(20)}};
        syms[0] = 8'h00;
        send_decode(syms);
        syms = {NUM_DIGITS{alpha_char(33)}};
        syms[5] = 8'hFF;
        send_decode(syms);
        // An unknown symbol wins over a sum below the offset.
        syms = {NUM_DIGITS{alpha_char(0)}};
        syms[2] = "0";
        send_decode(syms);
        send_decode({NUM_DIGITS{8'h80}});
        send_offset_edges();
    endtask

    // Both registers at their extremes, including data bits above the mask width.
    task automatic test_config_extremes();
        set_config('0, '0);
        send_encode(32'h0000_0000);
        send_encode(32'hFFFF_FFFF);
        send_decode({NUM_DIGITS{alpha_char(0)}});
        set_config({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
        // A zero number under the all-ones mask plus the maximum offset passes 58^6,
        // so the top digit wraps.
        send_encode(32'hFFFF_FFFF);
        send_encode(32'h0000_0000);
        send_decode({NUM_DIGITS{alpha_char(57)}});
        send_offset_edges();
    endtask

    // The receiver holds off while the sender keeps offering, so the pipeline backs up.
    task automatic test_backpressure();
        drain_pipeline();
        send_idling = 1'b0;
        recv_idling = 1'b0;
        holdoff_request = 1'b1;
        for (int n = 0; n < BURST_ITEMS; n++) begin
            if (n[0]) begin
                send_encode($urandom);
            end else begin
                send_decode(symbols_of({$urandom_range(0, 7), $urandom}));
            end
        end
        // The sender now waits for every result before going on.
        drain_pipeline();
        send_idling = 1'b1;
        recv_idling = 1'b1;
    endtask

    task automatic send_random_item();
        int pick;
        t_syms syms;
        logic [MASK_W-1:0] av;
        pick = $urandom_range(0, 99);
        av = $urandom;
        if ($urandom_range(0, 15) == 0) av = $urandom_range(0, 1) ? '1 : '0;
        if (pick < 42) begin
            send_encode(av);
        end else if (pick < 78) begin
            for (int i = 0; i < NUM_DIGITS; i++) syms[i] = alpha_char($urandom_range(0, 57));
            send_decode(syms);
        end else if (pick < 88) begin
            send_decode(symbols_of(longint'(av ^ mask_shadow) + longint'(offset_shadow)));
        end else if (pick < 91) begin
            send_offset_edges();
        end else begin
            // Noise: each symbol is a random byte or a code character.
            for (int i = 0; i < NUM_DIGITS; i++) begin
                syms[i] = $urandom_range(0, 1) ? 8'($urandom) : alpha_char($urandom_range(0, 57));
            end
            send_decode(syms);
        end
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] mask_data;
        logic [CFG_DATA_W-1:0] offset_data;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mask_data   = {3'($urandom_range(0, 7)), $urandom};
            offset_data = {3'($urandom_range(0, 7)), $urandom};
            case (p)
                1: begin
                    mask_data   = '0;
                    offset_data = '0;
                end
                3: begin
                    mask_data   = {CFG_DATA_W{1'b1}};
                    offset_data = {CFG_DATA_W{1'b1}};
                end
                5: begin
                    mask_data   = CFG_DATA_W'(XOR_MASK_RST);
                    offset_data = ADD_OFFSET_RST;
                end
                default: begin
                end
            endcase
            set_config(mask_data, offset_data);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
        end
    endtask

    // Receiver: random stall spans, no stall while idling is off, or one long hold-off when the test asks for it.
    initial begin : receiver
        int span;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                i_stall <= 1'b1;
                span = HOLDOFF_CYCLES;
                holdoff_total += HOLDOFF_CYCLES;
            end else if (!recv_idling) begin
                i_stall <= 1'b0;
                span = 1;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
                span = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 48)
                                                    : $urandom_range(1, 3);
            end
            repeat (span - 1) @(negedge i_clk);
        end
    end

    // Compares each output transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_conv_result exp;
        t_syms got_code;
        if (i_rst_n) begin
            if (o_stall) input_stall_cycles++;
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("output transfer with no conversion outstanding");
                    fail_count++;
                end else begin
                    exp = pending_results.pop_front();
                    got_code = {o_code_5, o_code_4, o_code_3, o_code_2, o_code_1, o_code_0};
                    if (o_av_result !== exp.av) begin
                        $error("av_result: expected %0d, got %0d", exp.av, o_av_result);
                        fail_count++;
                    end
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (got_code[i] !== exp.code[i]) begin
                            $error("code_%0d: expected 0x%02h, got 0x%02h",
                                   i, exp.code[i], got_code[i]);
                            fail_count++;
                        end
                    end
                    if (o_status !== exp.status) begin
                        $error("status: expected %0d, got %0d", exp.status, o_status);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : run_limit
        #20_000_000;
        $display("av_bv_id_codec_unit regression: fail");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_cmd       = 1'b0;
        i_av_number = '0;
        i_sym_0     = '0;
        i_sym_1     = '0;
        i_sym_2     = '0;
        i_sym_3     = '0;
        i_sym_4     = '0;
        i_sym_5     = '0;
        mask_shadow   = XOR_MASK_RST;
        offset_shadow = ADD_OFFSET_RST;
        send_idling = 1'b1;
        recv_idling = 1'b1;
        holdoff_request = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_phases();
        drain_pipeline();

        $display("Covered %0d encode and %0d decode transfers (%0d unknown symbol, %0d underflow)",
                 encode_count, decode_count, bad_symbol_count, underflow_count);
        $display("over %0d register writes; receiver held off %0d cycles, input stalled %0d.",
                 cfg_write_count, holdoff_total, input_stall_cycles);
        if (fail_count == 0) begin
            $display("av_bv_id_codec_unit regression: pass");
        end else begin
            $display("av_bv_id_codec_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/avbv_pkg.sv
hw/rtl/avbv_digit_step.sv
hw/rtl/av_bv_id_codec_unit.sv
hw/rtl/avbv_checker.sv
tb/testbench.sv
